// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL files that check their own logic.
// Depends on nothing; the including scope provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/ash_pkg.sv -----
// Shared constants, types and helpers of the allocation size histogram.
// No dependencies; imported by ash_bucket, the histogram top and the testbench.
`default_nettype none

package ash_pkg;

  // Histogram geometry. Both grains are powers of two.
  localparam int MAX_SIZE     = 65536;
  localparam int SPLIT_SIZE   = 256;
  localparam int COARSE_GRAIN = 16;
  localparam int FINE_GRAIN   = 4;
  localparam int COUNT_WIDTH  = 32;

  localparam int FINE_OFFSET = (SPLIT_SIZE / FINE_GRAIN) - (SPLIT_SIZE / COARSE_GRAIN);
  localparam int MAX_INDEX   = (MAX_SIZE / COARSE_GRAIN) + FINE_OFFSET;
  localparam int BUCKETS     = MAX_INDEX + 1;
  localparam int IDX_W       = $clog2(BUCKETS);
  localparam int SIZE_W      = 32;
  localparam int OUT_CNT_W   = 32;
  localparam int FINE_SH     = $clog2(FINE_GRAIN);
  localparam int COARSE_SH   = $clog2(COARSE_GRAIN);

  localparam logic [1:0] OP_RECORD   = 2'd0;
  localparam logic [1:0] OP_QUERY    = 2'd1;
  localparam logic [1:0] OP_SNAPSHOT = 2'd2;

  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  localparam cnt_t COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // Low bits of a counter as seen on the result channel.
  function automatic logic [OUT_CNT_W-1:0] cnt_to_out(input cnt_t v);
    logic [COUNT_WIDTH+OUT_CNT_W-1:0] ext;
    ext = {{OUT_CNT_W{1'b0}}, v};
    return ext[OUT_CNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ash_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; the histogram instantiates it for both count stores.
`default_nettype none

module ash_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // A read at the address being written returns the old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- rtl/ash_bucket.sv -----
// Maps a byte size to its two-resolution histogram bucket.
// Depends on ash_pkg for the geometry constants.
`default_nettype none

module ash_bucket import ash_pkg::*; (
  input  wire logic [SIZE_W-1:0] size,
  output idx_t                   bkt
);

  localparam int SW = $clog2(MAX_SIZE) + 1;
  localparam int XW = SW + 2;
  localparam logic signed [XW-1:0] OFFSET_S = XW'(FINE_OFFSET);
  localparam logic signed [XW-1:0] MAXI_S   = XW'(MAX_INDEX);

  logic [SW-1:0]          lo;
  logic [SW-1:0]          fine_q;
  logic [SW-1:0]          coarse_q;
  logic signed [XW-1:0]   idx_s;
  logic                   big;
  logic                   fine;

  always_comb begin
    big      = size >= SIZE_W'(MAX_SIZE);
    fine     = size <= SIZE_W'(SPLIT_SIZE);
    lo       = {1'b0, size[SW-2:0]};
    fine_q   = (lo + SW'(FINE_GRAIN - 1)) >> FINE_SH;
    coarse_q = (lo + SW'(COARSE_GRAIN - 1)) >> COARSE_SH;
    if (fine) begin
      idx_s = $signed({2'b00, fine_q});
    end else begin
      idx_s = $signed({2'b00, coarse_q}) + OFFSET_S;
    end
    // Clamp into the bucket range; oversize goes to the top bucket.
    if (big || idx_s > MAXI_S) begin
      idx_s = MAXI_S;
    end else if (idx_s < 0) begin
      idx_s = '0;
    end
    bkt = idx_s[IDX_W-1:0];
  end

endmodule

`default_nettype wire

// ----- rtl/allocation_size_histogram.sv -----
// Allocation size histogram: bucket mapping, two count memories, sequencer.
// Depends on ash_pkg, ash_bucket, ash_ram and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_stall) carries items of opcode and req_size.
//   Record (0) bumps the size's bucket, saturating, and returns the new count;
//   query (1, and the unused code 3) returns the current count; both also
//   return the count captured at the last snapshot. Snapshot (2) copies all
//   buckets into the snapshot memory and returns an all-zero item.
//   Result channel (out_valid/out_stall) returns exactly one item per input
//   item, in order, from an output register.
//   Record and query: one item per cycle sustained while the receiver does
//   not stall; read at acceptance, then modify/write/output register.
//   An item that directly follows a record of the same bucket takes the count
//   from a forwarding register, since the memory write lands on its read edge.
//   Snapshot: the sweep walks the count memory's one read port, one bucket a
//   cycle, and input stays stalled until the all-zero item is loaded.
//   Reset: a clearing pass zeroes both memories, one bucket a cycle, with
//   in_stall high.
//   Receiver stall: the output register holds its item; one more item may
//   sit finished in the read stage, after which in_stall rises.
`default_nettype none
`include "assert_macros.svh"

module allocation_size_histogram import ash_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           in_opcode,
  input  wire logic [SIZE_W-1:0]    in_req_size,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [IDX_W-1:0]          out_bucket_index,
  output logic [OUT_CNT_W-1:0]      out_current_count,
  output logic [OUT_CNT_W-1:0]      out_previous_count
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SWEEP = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  localparam idx_t LAST_IDX = IDX_W'(MAX_INDEX);

  // Sequencer state and sweep pointer.
  logic [1:0] state_r, state_nxt;
  idx_t       ptr_r, ptr_nxt;

  // Read stage: item whose memory read is in flight.
  logic s1_valid_r, s1_valid_nxt;
  logic s1_rec_r, s1_rec_nxt;
  idx_t s1_bkt_r, s1_bkt_nxt;
  logic fwd_valid_r, fwd_valid_nxt;
  cnt_t fwd_data_r, fwd_data_nxt;

  // Snapshot write, issued in the cycle after its sweep read.
  logic swr_valid_r, swr_valid_nxt;
  idx_t swr_addr_r, swr_addr_nxt;

  // Output register.
  logic                 out_valid_r, out_valid_nxt;
  idx_t                 out_bkt_r, out_bkt_nxt;
  logic [OUT_CNT_W-1:0] out_cur_r, out_cur_nxt;
  logic [OUT_CNT_W-1:0] out_prev_r, out_prev_nxt;

  // Memory ports.
  logic cnt_we, cnt_re, snp_we, snp_re;
  idx_t cnt_waddr, cnt_raddr, snp_waddr;
  cnt_t cnt_wdata, cnt_rdata, snp_wdata, snp_rdata;

  idx_t in_bkt;
  logic accept, is_snap, out_free, s1_adv, drain_done;
  cnt_t old_cnt, new_cnt;

  ash_bucket u_bucket (
    .size (in_req_size),
    .bkt  (in_bkt)
  );

  ash_ram #(.DEPTH(BUCKETS), .WIDTH(COUNT_WIDTH), .AW(IDX_W)) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cnt_re),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  ash_ram #(.DEPTH(BUCKETS), .WIDTH(COUNT_WIDTH), .AW(IDX_W)) u_snap_ram (
    .clk   (clk),
    .we    (snp_we),
    .waddr (snp_waddr),
    .wdata (snp_wdata),
    .re    (snp_re),
    .raddr (in_bkt),
    .rdata (snp_rdata)
  );

  // Handshake: take an item only when idle and the read stage can move on.
  always_comb begin
    out_free   = !out_valid_r || !out_stall;
    s1_adv     = s1_valid_r && out_free;
    in_stall   = (state_r != ST_IDLE) || (s1_valid_r && !out_free);
    accept     = in_valid && !in_stall;
    is_snap    = in_opcode == OP_SNAPSHOT;
    drain_done = (state_r == ST_DRAIN) && out_free;
  end

  // Modify: forward the previous record's count when the read raced its write,
  // then increment a record's count unless saturated.
  always_comb begin
    old_cnt = fwd_valid_r ? fwd_data_r : cnt_rdata;
    new_cnt = old_cnt;
    if (s1_rec_r && old_cnt != COUNT_MAX) begin
      new_cnt = old_cnt + 1'b1;
    end
  end

  // Memory port steering.
  always_comb begin
    cnt_re    = (accept && !is_snap) || (state_r == ST_SWEEP);
    cnt_raddr = (state_r == ST_SWEEP) ? ptr_r : in_bkt;
    cnt_we    = 1'b0;
    cnt_waddr = s1_bkt_r;
    cnt_wdata = new_cnt;
    snp_re    = accept && !is_snap;
    snp_we    = swr_valid_r;
    snp_waddr = swr_addr_r;
    snp_wdata = cnt_rdata;
    if (state_r == ST_CLEAR) begin
      cnt_we    = 1'b1;
      cnt_waddr = ptr_r;
      cnt_wdata = '0;
      snp_we    = 1'b1;
      snp_waddr = ptr_r;
      snp_wdata = '0;
    end else if (s1_adv && s1_rec_r) begin
      cnt_we = 1'b1;
    end
  end

  // Sequencer and pipeline next state.
  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    s1_valid_nxt  = s1_valid_r;
    s1_rec_nxt    = s1_rec_r;
    s1_bkt_nxt    = s1_bkt_r;
    fwd_valid_nxt = fwd_valid_r;
    fwd_data_nxt  = fwd_data_r;
    swr_valid_nxt = state_r == ST_SWEEP;
    swr_addr_nxt  = ptr_r;
    out_valid_nxt = out_valid_r;
    out_bkt_nxt   = out_bkt_r;
    out_cur_nxt   = out_cur_r;
    out_prev_nxt  = out_prev_r;

    case (state_r)
      ST_CLEAR: begin
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == LAST_IDX) begin
          ptr_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && is_snap) begin
          state_nxt = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == LAST_IDX) begin
          ptr_nxt   = '0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Drain the read stage when it advances; refill it on accept.
    if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    if (accept) begin
      s1_valid_nxt  = !is_snap;
      s1_rec_nxt    = in_opcode == OP_RECORD;
      s1_bkt_nxt    = in_bkt;
      fwd_valid_nxt = s1_adv && s1_rec_r && (s1_bkt_r == in_bkt);
      fwd_data_nxt  = new_cnt;
    end

    // Load the output register from the read stage or the finished snapshot.
    if (out_free) begin
      out_valid_nxt = s1_adv || drain_done;
      if (s1_adv) begin
        out_bkt_nxt  = s1_bkt_r;
        out_cur_nxt  = cnt_to_out(new_cnt);
        out_prev_nxt = cnt_to_out(snp_rdata);
      end else begin
        out_bkt_nxt  = '0;
        out_cur_nxt  = '0;
        out_prev_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      ptr_r       <= '0;
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      swr_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      s1_valid_r  <= s1_valid_nxt;
      fwd_valid_r <= fwd_valid_nxt;
      swr_valid_r <= swr_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_rec_r   <= s1_rec_nxt;
    s1_bkt_r   <= s1_bkt_nxt;
    fwd_data_r <= fwd_data_nxt;
    swr_addr_r <= swr_addr_nxt;
    out_bkt_r  <= out_bkt_nxt;
    out_cur_r  <= out_cur_nxt;
    out_prev_r <= out_prev_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_bucket_index   = out_bkt_r;
  assign out_current_count  = out_cur_r;
  assign out_previous_count = out_prev_r;

  // The read stage is empty while the sweep owns the count memory.
  `ASH_ASSERT(a_sweep_excl, (state_r == ST_SWEEP || state_r == ST_DRAIN) |-> !s1_valid_r, "read stage busy during snapshot sweep")
  // Snapshot writes trail the sweep reads and never outlive it.
  `ASH_ASSERT(a_swr_in_sweep, swr_valid_r |-> (state_r == ST_SWEEP || state_r == ST_DRAIN), "snapshot write outside sweep")
  // A record never wraps its bucket back to zero.
  `ASH_ASSERT(a_no_wrap, (s1_adv && s1_rec_r) |-> (new_cnt != '0), "record count wrapped")
  // The pointer rests at zero between passes.
  `ASH_ASSERT_ALWAYS(a_ptr_idle, (rst_n && state_r == ST_IDLE) |-> (ptr_r == '0), "sweep pointer not at rest")

endmodule

`default_nettype wire

// ----- sim/allocation_size_histogram_tb.sv -----
// Self-checking testbench for the allocation size histogram: a scoreboard
// class predicts every result while a task and a receiver process drive the two handshake channels.
// Depends on ash_pkg and the allocation_size_histogram RTL.

module allocation_size_histogram_tb;
  import ash_pkg::*;

  // Spare opcode, decoded by the block as a query.
  localparam logic [1:0] OP_SPARE = 2'd3;

  // Cycles without any handshake before giving up. The snapshot sweep and
  // the clearing pass after reset each keep the input stalled while they
  // walk every bucket, and the long receiver hold adds its own stretch.
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 150;
  localparam int N_RANDOM    = 1200;
  localparam int N_CALM      = 150;
  localparam int N_BURST     = 24;

  // Histogram predictor plus the queue of results still owed by the block.
  class size_hist_scoreboard;
    typedef struct {
      idx_t                 want_bucket;
      logic [OUT_CNT_W-1:0] want_now;
      logic [OUT_CNT_W-1:0] want_snap;
    } hist_result_t;

    cnt_t         live_cnt [BUCKETS];
    cnt_t         snap_cnt [BUCKETS];
    hist_result_t due_q [$];
    int           errors;
    int           n_record;
    int           n_query;
    int           n_spare;
    int           n_snapshot;
    int           n_checked;
    cnt_t         peak;

    function new();
      foreach (live_cnt[i]) begin
        live_cnt[i] = '0;
        snap_cnt[i] = '0;
      end
      errors     = 0;
      n_record   = 0;
      n_query    = 0;
      n_spare    = 0;
      n_snapshot = 0;
      n_checked  = 0;
      peak       = '0;
    endfunction

    // Round up at the fine grain up to the split, at the coarse grain above
    // it, and send everything at or past the largest size to the top bucket.
    function idx_t bucket_for(logic [SIZE_W-1:0] size);
      longint unsigned sz;
      longint unsigned idx;
      sz = size;
      if (sz >= MAX_SIZE)
        idx = MAX_INDEX;
      else if (sz <= SPLIT_SIZE)
        idx = (sz + FINE_GRAIN - 1) / FINE_GRAIN;
      else
        idx = (sz + COARSE_GRAIN - 1) / COARSE_GRAIN + FINE_OFFSET;
      if (idx > MAX_INDEX)
        idx = MAX_INDEX;
      return idx_t'(idx);
    endfunction

    function void note_item(logic [1:0] op, logic [SIZE_W-1:0] size);
      hist_result_t r;
      idx_t         b;
      if (op == OP_SNAPSHOT) begin
        foreach (live_cnt[i]) snap_cnt[i] = live_cnt[i];
        r.want_bucket = '0;
        r.want_now    = '0;
        r.want_snap   = '0;
        n_snapshot++;
      end else begin
        b = bucket_for(size);
        if (op == OP_RECORD) begin
          n_record++;
          if (live_cnt[b] != COUNT_MAX)
            live_cnt[b] = live_cnt[b] + 1'b1;
          if (live_cnt[b] > peak)
            peak = live_cnt[b];
        end else if (op == OP_QUERY) begin
          n_query++;
        end else begin
          n_spare++;
        end
        r.want_bucket = b;
        r.want_now    = OUT_CNT_W'(live_cnt[b]);
        r.want_snap   = OUT_CNT_W'(snap_cnt[b]);
      end
      due_q.push_back(r);
    endfunction

    // Print one line per mismatch and count it.
    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("mismatch at result %0d: %s got %0d want %0d", n_checked, what, got, want);
    endtask

    task check_result(idx_t got_b, logic [OUT_CNT_W-1:0] got_now,
                      logic [OUT_CNT_W-1:0] got_snap);
      hist_result_t r;
      if (due_q.size() == 0) begin
        report_mismatch("result with nothing outstanding, bucket", 64'(got_b), 64'(0));
        return;
      end
      r = due_q.pop_front();
      n_checked++;
      if (got_b !== r.want_bucket)
        report_mismatch("bucket_index", 64'(got_b), 64'(r.want_bucket));
      if (got_now !== r.want_now)
        report_mismatch("current_count", 64'(got_now), 64'(r.want_now));
      if (got_snap !== r.want_snap)
        report_mismatch("previous_count", 64'(got_snap), 64'(r.want_snap));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_opcode = OP_RECORD;
  logic [SIZE_W-1:0]    in_req_size = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [IDX_W-1:0]     out_bucket_index;
  logic [OUT_CNT_W-1:0] out_current_count;
  logic [OUT_CNT_W-1:0] out_previous_count;

  size_hist_scoreboard sb;

  // Shared control between the sender and the receiver processes.
  bit gaps_on      = 1'b1;  // sender may insert idle bursts
  bit calm         = 1'b0;  // final stretch: nobody idles
  bit hold_pending = 1'b0;  // sender asks the receiver for one long hold
  int quiet        = 0;

  logic [SIZE_W-1:0] last_size = '0;
  logic [SIZE_W-1:0] hot_sizes [8];
  logic [SIZE_W-1:0] corner_sizes [16] = '{
    32'd0, 32'd1, 32'd3, 32'd4, 32'd5, 32'd255, 32'd256, 32'd257,
    32'd271, 32'd272, 32'd273, 32'd65535, 32'd65536, 32'd65537,
    32'h8000_0000, 32'hFFFF_FFFF
  };

  allocation_size_histogram i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_req_size        (in_req_size),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_bucket_index   (out_bucket_index),
    .out_current_count  (out_current_count),
    .out_previous_count (out_previous_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Offer one item from the falling edge and hold it until the block takes
  // it; then, if idling is allowed, drop valid for a short random burst.
  task automatic send_item(input logic [1:0] op, input logic [SIZE_W-1:0] size);
    int gap;
    @(negedge clk);
    in_valid    <= 1'b1;
    in_opcode   <= op;
    in_req_size <= size;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(op, size);
    last_size = size;
    if (gaps_on && $urandom_range(3) == 0) begin
      gap = $urandom_range(1, 5);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Stop offering and wait until the block has returned every result owed.
  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.due_q.size() != 0) @(posedge clk);
  endtask

  // Mix sizes so that the same buckets are hit again and again (counts grow,
  // back-to-back records exercise forwarding) while the corners and the
  // full 32-bit range still show up.
  function automatic logic [SIZE_W-1:0] pick_size();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 30)      return $urandom_range(0, 300);
    else if (k < 45) return hot_sizes[$urandom_range(0, 7)];
    else if (k < 55) return last_size;
    else if (k < 70) return $urandom_range(301, 70000);
    else if (k < 80) return $urandom_range(MAX_SIZE - 24, MAX_SIZE + 24);
    else if (k < 90) return $urandom();
    else             return corner_sizes[$urandom_range(0, 15)];
  endfunction

  // Receiver: random stall bursts in some stretches, none in others, one long
  // hold on request, and no stalls at all once calm.
  initial begin : receiver
    int  burst;
    int  stretch;
    int  hold_left;
    bit  stalls_on;
    logic nxt;
    burst     = 0;
    stretch   = 0;
    hold_left = 0;
    stalls_on = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left    = HOLD_CYCLES - 1;
        nxt          = 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
        nxt = 1'b1;
      end else if (calm) begin
        nxt = 1'b0;
      end else begin
        if (stretch == 0) begin
          stretch   = $urandom_range(20, 80);
          stalls_on = ($urandom_range(3) != 0);
        end
        stretch--;
        if (burst > 0) begin
          burst--;
          nxt = 1'b1;
        end else if (stalls_on && $urandom_range(4) == 0) begin
          burst = $urandom_range(0, 4);
          nxt   = 1'b1;
        end else begin
          nxt = 1'b0;
        end
      end
      out_stall <= nxt;
    end
  end

  // Check every accepted result and watch for a hung handshake.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet = 0;
    end else begin
      if (out_valid && !out_stall)
        sb.check_result(out_bucket_index, out_current_count, out_previous_count);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
                 quiet, sb.due_q.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int          k;
    logic [1:0]  op;
    sb = new();
    foreach (hot_sizes[i])
      hot_sizes[i] = (i < 5) ? $urandom_range(0, 512) : $urandom_range(513, 70000);

    // Hold reset; the block then runs its clearing pass with in_stall high.
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: split and top boundaries, rounding, repeats, every opcode.
    send_item(OP_RECORD, 32'd0);
    send_item(OP_RECORD, 32'd1);
    send_item(OP_RECORD, 32'd4);            // same bucket as 1
    send_item(OP_RECORD, 32'd5);
    send_item(OP_RECORD, 32'd256);          // last fine-grain size
    send_item(OP_RECORD, 32'd257);          // first coarse-grain size
    send_item(OP_RECORD, 32'd272);
    send_item(OP_RECORD, 32'd273);
    send_item(OP_RECORD, 32'd65535);
    send_item(OP_RECORD, 32'd65536);        // top bucket from here on
    send_item(OP_RECORD, 32'hFFFF_FFFF);
    send_item(OP_RECORD, 32'h8000_0000);
    send_item(OP_QUERY, 32'd4);
    send_item(OP_SPARE, 32'd65536);
    send_item(OP_SNAPSHOT, 32'hFFFF_FFFF);
    send_item(OP_RECORD, 32'd4);
    send_item(OP_SPARE, 32'hFFFF_FFFF);
    send_item(OP_QUERY, 32'd0);
    send_item(OP_RECORD, 32'd3);
    send_item(OP_RECORD, 32'd2);
    send_item(OP_SNAPSHOT, 32'd0);
    send_item(OP_SNAPSHOT, 32'd12345);      // snapshot right after a snapshot
    send_item(OP_QUERY, 32'd1);

    // Fill the block: the receiver holds for a long stretch while items
    // keep coming with no gaps, so in_stall must rise and later release.
    gaps_on      = 1'b0;
    hold_pending = 1'b1;
    for (int i = 0; i < N_BURST; i++)
      send_item((i % 3 == 2) ? OP_QUERY : OP_RECORD, hot_sizes[i % 3]);
    wait_for_results();
    gaps_on = 1'b1;

    // Random traffic; pause once in the middle until everything is back,
    // and run the final stretch with no idling on either side.
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2)
        wait_for_results();
      if (i == N_RANDOM - N_CALM) begin
        calm    = 1'b1;
        gaps_on = 1'b0;
      end else if (!calm && i % 50 == 0) begin
        gaps_on = ($urandom_range(3) != 0);
      end
      k = $urandom_range(199);
      if (k < 120)      op = OP_RECORD;
      else if (k < 184) op = OP_QUERY;
      else if (k < 198) op = OP_SPARE;
      else              op = OP_SNAPSHOT;
      send_item(op, pick_size());
    end

    // Drain, then keep watching for any stray result to show up.
    wait_for_results();
    repeat (10) @(posedge clk);
    if (sb.due_q.size() != 0)
      sb.report_mismatch("results never returned", 64'(sb.due_q.size()), 64'(0));

    $display("covered %0d records, %0d queries, %0d spare-opcode queries, %0d snapshots",
             sb.n_record, sb.n_query, sb.n_spare, sb.n_snapshot);
    $display("checked %0d results, %0d mismatches, highest bucket count %0d",
             sb.n_checked, sb.errors, sb.peak);
    if (sb.errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
